// File: design/fnd_pkg.sv
// ----------------------------------------------------------------------------
// fnd_pkg: shared types and constants for the four-neighbour despeckler
// Field widths, register indexes, sequencer states, accumulator control
// and the level-to-glyph lookup.
// ----------------------------------------------------------------------------
package fnd_pkg;

    // field widths
    localparam int LEVEL_W    = 4;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 6;
    localparam int GLYPH_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // neighbour sum of up to four levels, and neighbour count
    localparam int SUM_W = 6;
    localparam int CNT_W = 3;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 4'd9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b1;

    localparam logic [ROW_W-1:0] ROWS_RESET = 10'd20;
    localparam logic [COL_W-1:0] COLS_RESET = 6'd30;
    localparam logic [ROW_W-1:0] MIN_ROWS   = 10'd2;
    localparam logic [COL_W-1:0] MIN_COLS   = 6'd2;

    // line store read slots
    localparam logic [1:0] SLOT_CENTRE = 2'd0;
    localparam logic [1:0] SLOT_UP     = 2'd1;
    localparam logic [1:0] SLOT_LEFT   = 2'd2;
    localparam logic [1:0] SLOT_RIGHT  = 2'd3;

    // reciprocal of 6 scaled by 256, exact for dividends below 64
    localparam logic [5:0] RECIP6 = 6'd43;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TAIL,
        ST_DOWN,
        ST_EMIT,
        ST_WRITE
    } fsm_state_t;

    // control of the shared neighbour accumulator
    typedef struct packed {
        logic load;   // take the centre level, clear the sums
        logic feed;   // take one neighbour
        logic ok;     // that neighbour lies inside the image
    } acc_ctl_t;

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] level);
        logic [GLYPH_W-1:0] g;
        begin
            unique case (level)
                4'd0:    g = 7'd32;
                4'd1:    g = 7'd46;
                4'd2:    g = 7'd39;
                4'd3:    g = 7'd58;
                4'd4:    g = 7'd126;
                4'd5:    g = 7'd42;
                4'd6:    g = 7'd61;
                4'd7:    g = 7'd38;
                4'd8:    g = 7'd37;
                default: g = 7'd35;
            endcase
            return g;
        end
    endfunction

endpackage

// File: design/fnd_ifs.sv
// ----------------------------------------------------------------------------
// fnd_ifs: valid/ready channels of the despeckler
// Pixel channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface fnd_pix_if
    import fnd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pixel_level;

    modport source (output valid, output pixel_level, input ready);
    modport sink   (input valid, input pixel_level, output ready);
endinterface

interface fnd_res_if
    import fnd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [LEVEL_W-1:0] clean_level;
    logic [GLYPH_W-1:0] glyph_code;
    logic               image_done;

    modport source (output valid, output out_row, output out_col, output clean_level,
                    output glyph_code, output image_done, input ready);
    modport sink   (input valid, input out_row, input out_col, input clean_level,
                    input glyph_code, input image_done, output ready);
endinterface

// File: design/four_neighbour_despeckle_to_glyph_top.sv
// ----------------------------------------------------------------------------
// four_neighbour_despeckle_to_glyph_top: despeckle filter with glyph output
// Two-row line store, small read/accumulate sequencer and output register.
// ----------------------------------------------------------------------------
// Usage:
//   pixel   : grey levels 0..9 in raster order, one word per handshake.
//   result  : row, column, cleaned level, glyph and end-of-image flag.
//   cfg_*   : write image_rows (index 0) and image_cols (index 1) while idle.
// Results trail the input by one row: a pixel of row r releases the pixel
// of row r-1 above it, and the last pixel of an image also releases the
// whole last row, the final word carrying image_done.
// Timing: a row 0 pixel goes straight to write-back; any other pixel runs
// four line store reads through the single read port, one neighbour a cycle
// into the shared accumulator, emit, write-back. The last pixel adds the
// reads, accumulation and emit of each column of the flush. A result shows
// in the cycle after its emit step.
// The output register frees the pixel side: a new pixel is taken while a
// word waits, but the sequencer holds in its emit step while the receiver
// stalls and a word is still pending.
// Reset clears position, registers (rows 20, columns 30) and handshakes;
// the line store needs no clearing.
// ----------------------------------------------------------------------------
module four_neighbour_despeckle_to_glyph_top
    import fnd_pkg::*;
#(
    parameter int MAX_COLS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fnd_pix_if.sink               pixel,
    fnd_res_if.source             result
);

    localparam int DEPTH = 2 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    // configuration and position
    logic [ROW_W-1:0] image_rows_reg;
    logic [COL_W-1:0] image_cols_reg;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [COL_W-1:0] col_pos_reg, col_pos_next;

    // sequencer
    fsm_state_t       state_reg, state_next;
    logic [1:0]       slot_reg, slot_next;
    logic             flush_reg, flush_next;

    // working item
    logic [ROW_W-1:0]   r_reg, r_next;
    logic [COL_W-1:0]   ocol_reg, ocol_next;
    logic [COL_W-1:0]   ec_reg, ec_next;
    logic [LEVEL_W-1:0] px_reg, px_next;
    logic               last_img_reg, last_img_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [LEVEL_W-1:0] clean_level_reg;
    logic [GLYPH_W-1:0] glyph_code_reg;
    logic               image_done_reg;
    logic               emit_load;

    // line store
    logic [LEVEL_W-1:0] mem [DEPTH];
    logic [LEVEL_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               mem_we;
    logic               rd_half;
    logic [COL_W-1:0]   rd_col;

    // accumulator link
    acc_ctl_t           acc_ctl;
    logic [LEVEL_W-1:0] acc_data;
    logic [LEVEL_W-1:0] acc_result;

    // effective bounds and position of the incoming pixel
    logic [ROW_W-1:0]   eff_rows;
    logic [COL_W-1:0]   eff_cols;
    logic [ROW_W-1:0]   eff_row;
    logic [COL_W-1:0]   eff_col;
    logic               last_col;
    logic               last_row;
    logic [LEVEL_W-1:0] px_sat;

    // neighbour flags of the pixel being filtered
    logic               centre_half;
    logic               up_ok;
    logic               left_ok;
    logic               right_ok;
    logic               last_out_col;

    // clamp the bounds and the position
    always_comb
    begin
        eff_rows = (image_rows_reg < MIN_ROWS) ? MIN_ROWS : image_rows_reg;
        if (image_cols_reg < MIN_COLS)
            eff_cols = MIN_COLS;
        else if (image_cols_reg > COL_W'(MAX_COLS))
            eff_cols = COL_W'(MAX_COLS);
        else
            eff_cols = image_cols_reg;
        eff_row  = (row_pos_reg >= eff_rows) ? (eff_rows - 10'd1) : row_pos_reg;
        eff_col  = (col_pos_reg >= eff_cols) ? (eff_cols - 6'd1) : col_pos_reg;
        last_col = (eff_col == eff_cols - 6'd1);
        last_row = (eff_row == eff_rows - 10'd1);
        px_sat   = (pixel.pixel_level > MAX_LEVEL) ? MAX_LEVEL : pixel.pixel_level;
    end

    // the row above lives in the other half; the flush row in its own half
    assign centre_half  = flush_reg ? r_reg[0] : ~r_reg[0];
    assign up_ok        = flush_reg | (|r_reg[ROW_W-1:1]);
    assign left_ok      = (ocol_reg != '0);
    assign right_ok     = (ocol_reg != ec_reg - 6'd1);
    assign last_out_col = (ocol_reg == ec_reg - 6'd1);

    // read address for the current slot
    always_comb
    begin
        unique case (slot_reg)
            SLOT_CENTRE:
            begin
                rd_half = centre_half;
                rd_col  = ocol_reg;
            end
            SLOT_UP:
            begin
                rd_half = ~centre_half;
                rd_col  = ocol_reg;
            end
            SLOT_LEFT:
            begin
                rd_half = centre_half;
                rd_col  = left_ok ? (ocol_reg - 6'd1) : ocol_reg;
            end
            default:
            begin
                rd_half = centre_half;
                rd_col  = right_ok ? (ocol_reg + 6'd1) : ocol_reg;
            end
        endcase
    end

    assign rd_addr = (rd_half ? AW'(MAX_COLS) : AW'(0)) + AW'(rd_col);
    assign wr_addr = (r_reg[0] ? AW'(MAX_COLS) : AW'(0)) + AW'(ocol_reg);

    // line store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= px_reg;
        rd_data_reg <= mem[rd_addr];
    end

    assign acc_data = (state_reg == ST_DOWN) ? px_reg : rd_data_reg;

    fnd_acc u_acc (
        .clk    (clk),
        .ctl    (acc_ctl),
        .data   (acc_data),
        .result (acc_result)
    );

    // sequencer: next state and controls
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        flush_next    = flush_reg;
        r_next        = r_reg;
        ocol_next     = ocol_reg;
        ec_next       = ec_reg;
        px_next       = px_reg;
        last_img_next = last_img_reg;
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        emit_load     = 1'b0;
        mem_we        = 1'b0;
        acc_ctl       = '0;
        pixel.ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                pixel.ready = 1'b1;
                if (pixel.valid)
                begin
                    r_next        = eff_row;
                    ocol_next     = eff_col;
                    ec_next       = eff_cols;
                    px_next       = px_sat;
                    last_img_next = last_col && last_row;
                    flush_next    = 1'b0;
                    slot_next     = SLOT_CENTRE;
                    if (last_col)
                    begin
                        col_pos_next = '0;
                        row_pos_next = last_row ? '0 : (eff_row + 10'd1);
                    end
                    else
                    begin
                        col_pos_next = eff_col + 6'd1;
                        row_pos_next = eff_row;
                    end
                    state_next = (eff_row != '0) ? ST_READ : ST_WRITE;
                end
            end
            ST_READ:
            begin
                // data of the previous slot arrives now
                slot_next = slot_reg + 2'd1;
                unique case (slot_reg)
                    SLOT_CENTRE: acc_ctl = '0;
                    SLOT_UP:     acc_ctl.load = 1'b1;
                    SLOT_LEFT:
                    begin
                        acc_ctl.feed = 1'b1;
                        acc_ctl.ok   = up_ok;
                    end
                    default:
                    begin
                        acc_ctl.feed = 1'b1;
                        acc_ctl.ok   = left_ok;
                        state_next   = ST_TAIL;
                    end
                endcase
            end
            ST_TAIL:
            begin
                acc_ctl.feed = 1'b1;
                acc_ctl.ok   = right_ok;
                state_next   = ST_DOWN;
            end
            ST_DOWN:
            begin
                // the incoming pixel is the lower neighbour
                acc_ctl.feed = 1'b1;
                acc_ctl.ok   = ~flush_reg;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    emit_load = 1'b1;
                    slot_next = SLOT_CENTRE;
                    if (!flush_reg)
                        state_next = ST_WRITE;
                    else if (last_out_col)
                        state_next = ST_IDLE;
                    else
                    begin
                        ocol_next  = ocol_reg + 6'd1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (last_img_reg)
                begin
                    flush_next = 1'b1;
                    ocol_next  = '0;
                    slot_next  = SLOT_CENTRE;
                    state_next = ST_READ;
                end
                else
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output handshake
    always_comb
    begin
        if (emit_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_reg       <= SLOT_CENTRE;
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            image_rows_reg <= ROWS_RESET;
            image_cols_reg <= COLS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                    REG_IMAGE_COLS: image_cols_reg <= cfg_data[COL_W-1:0];
                    default:        image_rows_reg <= image_rows_reg;
                endcase
            end
        end
    end

    // working item and output word
    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        ocol_reg     <= ocol_next;
        ec_reg       <= ec_next;
        px_reg       <= px_next;
        last_img_reg <= last_img_next;
        if (emit_load)
        begin
            out_row_reg     <= flush_reg ? r_reg : (r_reg - 10'd1);
            out_col_reg     <= ocol_reg;
            clean_level_reg <= acc_result;
            glyph_code_reg  <= glyph_of(acc_result);
            image_done_reg  <= flush_reg && last_out_col;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.out_row     = out_row_reg;
    assign result.out_col     = out_col_reg;
    assign result.clean_level = clean_level_reg;
    assign result.glyph_code  = glyph_code_reg;
    assign result.image_done  = image_done_reg;

`ifndef SYNTH
    // a stalled receiver holds the sequencer in its emit step
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && result.valid && !result.ready) |=> (state_reg == ST_EMIT))
        else $error("emit step left while a word was still pending");

    // the column being filtered stays inside the image
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (ocol_reg < ec_reg))
        else $error("working column beyond image width");

    // the line store is never written during the flush run
    a_no_flush_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> !flush_reg)
        else $error("line store write during flush");

    // the end-of-image word is the last column of the image
    a_done_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.image_done) |-> (result.out_col == ec_reg - 6'd1))
        else $error("image_done away from the last column");
`endif

endmodule

// File: design/fnd_acc.sv
// ----------------------------------------------------------------------------
// fnd_acc: shared neighbour accumulator
// Takes a centre level, then one neighbour per cycle; keeps the in-bounds
// count, the far-neighbour count and sum, and gives the despeckled level.
// ----------------------------------------------------------------------------
module fnd_acc
    import fnd_pkg::*;
(
    input  logic               clk,
    input  acc_ctl_t           ctl,
    input  logic [LEVEL_W-1:0] data,
    output logic [LEVEL_W-1:0] result
);

    logic [LEVEL_W-1:0] v_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   inb_reg;

    logic [LEVEL_W-1:0] diff;
    logic               far;
    logic [6:0]         x_half;
    logic [6:0]         x_quarter;
    logic [6:0]         x_third;
    logic [12:0]        prod_third;

    // distance from the centre
    assign diff = (data > v_reg) ? (data - v_reg) : (v_reg - data);
    assign far  = (diff > 4'd1);

    // accumulate one neighbour per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            v_reg   <= data;
            sum_reg <= '0;
            cnt_reg <= '0;
            inb_reg <= '0;
        end
        else if (ctl.feed && ctl.ok)
        begin
            inb_reg <= inb_reg + 3'd1;
            if (far)
            begin
                sum_reg <= sum_reg + SUM_W'(data);
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    // rounded average (2*sum+cnt)/(2*cnt) for cnt of 1 to 4
    assign x_half     = 7'(sum_reg) + 7'd1;
    assign x_quarter  = 7'(sum_reg) + 7'd2;
    assign x_third    = {sum_reg, 1'b0} + 7'd3;
    assign prod_third = 13'(x_third) * 13'(RECIP6);

    always_comb
    begin
        if (cnt_reg == '0 || cnt_reg != inb_reg)
        begin
            result = v_reg;
        end
        else
        begin
            unique case (cnt_reg)
                3'd1:    result = sum_reg[LEVEL_W-1:0];
                3'd2:    result = x_half[4:1];
                3'd3:    result = prod_third[11:8];
                default: result = x_quarter[5:2];
            endcase
        end
    end

endmodule
